// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ADP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ADP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) \
      else $error(msg);

`endif

// ----- rtl/adp_pkg.sv -----
// types, constants and character helpers of the decimal line parser
`default_nettype none
package adp_pkg;

   localparam int VALUE_W = 31;
   localparam int CHAR_W  = 8;

   localparam logic [CHAR_W-1:0] EOL_CODE  = 8'd10;
   localparam logic [CHAR_W-1:0] BLANK_MAX = 8'd32;
   localparam logic [CHAR_W-1:0] DIGIT_LO  = 8'd48;
   localparam logic [CHAR_W-1:0] DIGIT_HI  = 8'd57;

   localparam logic [VALUE_W-1:0] MAX_VALUE_RESET = 31'h7FFF_FFFF;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_PARSE = 2'd1;
   localparam logic [1:0] STATUS_READ  = 2'd2;
   localparam logic [1:0] STATUS_NONE  = 2'd3;

   typedef enum logic [3:0] {
      PH_LEAD   = 4'b0001,
      PH_DIGITS = 4'b0010,
      PH_TRAIL  = 4'b0100,
      PH_BAD    = 4'b1000
   } phase_type;

   typedef struct packed {
      logic take_digit;
      logic clear_line;
   } acc_ctrl_type;

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      return (c <= BLANK_MAX) || c[CHAR_W-1];
   endfunction

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= DIGIT_LO) && (c <= DIGIT_HI);
   endfunction

endpackage
`default_nettype wire

// ----- rtl/adp_accum.sv -----
// decimal accumulator with sticky over-maximum flag
`default_nettype none
`include "assert_macros.svh"
module adp_accum (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire adp_pkg::acc_ctrl_type         ctrl,
   input  wire logic [3:0]                    digit,
   input  wire logic [adp_pkg::VALUE_W-1:0]   max_value,
   output logic      [adp_pkg::VALUE_W-1:0]   acc_value,
   output logic                               over_max
);
   import adp_pkg::*;

   localparam int NEXT_W = VALUE_W + 4;

   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               over_ff, over_in;
   logic [NEXT_W-1:0]  next_val;

   // acc * 10 + digit as shifts and adds
   assign next_val = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                     + {{(NEXT_W-4){1'b0}}, digit};

   always_comb begin
      acc_in  = acc_ff;
      over_in = over_ff;
      if (ctrl.clear_line) begin
         acc_in  = '0;
         over_in = 1'b0;
      end else if (ctrl.take_digit && !over_ff) begin
         if (next_val > {4'b0000, max_value}) begin
            over_in = 1'b1;
         end else begin
            acc_in = next_val[VALUE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         over_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         over_ff <= over_in;
      end
   end

   assign acc_value = acc_ff;
   assign over_max  = over_ff;

   `ADP_ASSERT_NEXT(a_over_sticky, clock, reset, over_ff && !ctrl.clear_line, over_ff,
      "over_max dropped without a line clear")
   `ADP_ASSERT_NEXT(a_line_clear, clock, reset, ctrl.clear_line, (acc_ff == '0) && !over_ff,
      "accumulator not cleared at line end")
   `ADP_ASSERT_NEXT(a_acc_hold, clock, reset, !ctrl.take_digit && !ctrl.clear_line,
      $stable(acc_ff), "accumulator moved without a digit")

endmodule
`default_nettype wire

// ----- rtl/ascii_decimal_line_parser.sv -----
// a line end or end-of-input item is staged in the input register, then registered on rsp
// throughput: one character item per cycle, set by the single input register stage
// a result that waits on rsp_ready holds the pipe only when the next item also ends a line
// reset: synchronous, clears the line state, handshakes and sets max_value to 2^31-1
// no memories, so no clearing pass after reset
`default_nettype none
`include "assert_macros.svh"
module ascii_decimal_line_parser #(
   parameter int LINE_BUFFER_LEN = 10
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // character items
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [adp_pkg::CHAR_W-1:0]    req_char_code,
   input  wire logic                          req_end_of_input,
   // result items
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [adp_pkg::VALUE_W-1:0]   rsp_value,
   output logic      [1:0]                    rsp_status,
   // max_value register
   input  wire logic                          csr_wr_en,
   input  wire logic [adp_pkg::VALUE_W-1:0]   csr_wr_data
);
   import adp_pkg::*;

   localparam int CNT_W = $clog2(LINE_BUFFER_LEN + 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_BUFFER_LEN);

   // configuration
   logic [VALUE_W-1:0] max_value_ff;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0]  char_ff;
   logic               eoi_ff;

   // line state
   phase_type          phase_ff, phase_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               too_long_ff, too_long_in;
   logic               seen_ff, seen_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] value_ff;
   logic [1:0]         status_ff;

   logic               is_eol, emit, out_free, advance, accept;
   logic               blank, digit, take;
   logic [1:0]         status_new;
   logic [VALUE_W-1:0] acc_value;
   logic               over_max;
   acc_ctrl_type       acc_ctrl;

   // ---------------------------------------------------------------- flow control
   // the staged item moves on unless it makes a result and the output is still full
   assign is_eol   = (char_ff == EOL_CODE);
   assign emit     = in_valid_ff && (eoi_ff || is_eol);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = in_valid_ff && (!emit || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign accept   = req_valid && req_ready;

   assign in_valid_in = accept || (in_valid_ff && !advance);

   // ---------------------------------------------------------------- character class
   assign blank = is_blank(char_ff);
   assign digit = is_digit(char_ff);

   // ---------------------------------------------------------------- line state update
   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      too_long_in = too_long_ff;
      seen_in     = seen_ff;
      take        = 1'b0;
      if (advance) begin
         if (emit) begin
            // line done, start over
            phase_in    = PH_LEAD;
            count_in    = '0;
            too_long_in = 1'b0;
            seen_in     = 1'b0;
         end else if (count_ff < CNT_LIMIT) begin
            count_in = count_ff + CNT_W'(1);
            unique case (phase_ff)
               PH_LEAD: begin
                  if (digit) begin
                     phase_in = PH_DIGITS;
                     take     = 1'b1;
                  end else if (!blank) begin
                     phase_in = PH_BAD;
                  end
               end
               PH_DIGITS: begin
                  if (digit) begin
                     take = 1'b1;
                  end else if (blank) begin
                     phase_in = PH_TRAIL;
                  end else begin
                     phase_in = PH_BAD;
                  end
               end
               PH_TRAIL: begin
                  if (!blank) begin
                     phase_in = PH_BAD;
                  end
               end
               PH_BAD: begin
                  phase_in = PH_BAD;
               end
               default: begin
                  phase_in = PH_BAD;
               end
            endcase
            if (take) begin
               seen_in = 1'b1;
            end
         end else begin
            // bytes past the buffer are dropped, only flagged
            too_long_in = 1'b1;
         end
      end
   end

   assign acc_ctrl.take_digit = take;
   assign acc_ctrl.clear_line = advance && emit;

   adp_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (acc_ctrl),
      .digit     (char_ff[3:0]),
      .max_value (max_value_ff),
      .acc_value (acc_value),
      .over_max  (over_max)
   );

   // ---------------------------------------------------------------- result
   // read error wins, then any parse problem
   always_comb begin
      priority if (eoi_ff) begin
         status_new = STATUS_READ;
      end else if (too_long_ff || (phase_ff == PH_BAD) || !seen_ff || over_max) begin
         status_new = STATUS_PARSE;
      end else begin
         status_new = STATUS_OK;
      end
   end

   assign rsp_valid_in = (advance && emit) || (rsp_valid_ff && !rsp_ready);

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_value_ff <= MAX_VALUE_RESET;
         in_valid_ff  <= 1'b0;
         phase_ff     <= PH_LEAD;
         count_ff     <= '0;
         too_long_ff  <= 1'b0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_value_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         too_long_ff  <= too_long_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         char_ff <= req_char_code;
         eoi_ff  <= req_end_of_input;
      end
      if (advance && emit) begin
         status_ff <= status_new;
         value_ff  <= (status_new == STATUS_OK) ? acc_value : '0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;

   // ---------------------------------------------------------------- checks
   `ADP_ASSERT(a_err_value_zero, clock, reset,
      rsp_valid_ff && (status_ff != STATUS_OK) |-> value_ff == '0,
      "error result with nonzero value")
   `ADP_ASSERT(a_status_code, clock, reset, rsp_valid_ff |-> status_ff != STATUS_NONE,
      "result status out of range")
   `ADP_ASSERT(a_count_limit, clock, reset, count_ff <= CNT_LIMIT,
      "char count past line buffer length")
   `ADP_ASSERT_NEXT(a_bad_sticky, clock, reset,
      (phase_ff == PH_BAD) && !(advance && emit), phase_ff == PH_BAD,
      "bad phase left before line end")

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// self-checking testbench for the ascii decimal line parser: directed table, then random lines
`timescale 1ns / 1ps
module tb_top;
   import adp_pkg::*;

   localparam int LINE_LEN   = 10;    // line buffer length given to the block
   localparam int DIR_ROWS   = 26;
   localparam int PHASES     = 10;
   localparam int PHASE_ITEMS = 185;  // about 1850 random items over all phases
   localparam int PRINT_CAP  = 40;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [1:0]         status;
   } line_result_type;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   // one row of the directed table; a cfg row carries the new max_value in val
   typedef struct packed {
      row_kind_type       kind;
      logic [CHAR_W-1:0]  code;
      logic               eoi;
      logic               typed;
      logic [VALUE_W-1:0] val;
      logic [1:0]         st;
   } stim_row_type;

   // dut connections, the inputs driven to known values from time zero
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CHAR_W-1:0]   req_char_code = '0;
   logic                req_end_of_input = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [VALUE_W-1:0]  rsp_value;
   logic [1:0]          rsp_status;
   logic                csr_wr_en = 1'b0;
   logic [VALUE_W-1:0]  csr_wr_data = '0;

   // typed expectation that travels with the item, held like the payload
   logic                row_typed = 1'b0;
   logic [VALUE_W-1:0]  row_value = '0;
   logic [1:0]          row_status = STATUS_OK;

   // predictor copy of the line state and the register
   phase_type           line_phase;
   int                  line_count;
   bit                  line_long;
   longint              line_acc;
   bit                  line_over;
   bit                  line_digit;
   logic [VALUE_W-1:0]  line_max;

   line_result_type     pending_results[$];
   logic [CHAR_W-1:0]   line_bytes[$];
   stim_row_type        directed_rows [DIR_ROWS];

   bit                  idle_en = 1'b1;
   int                  burst_left = 0;
   int                  mismatch_count = 0;
   int                  items_sent = 0;
   int                  results_checked = 0;
   int                  cfg_writes = 0;
   int                  status_seen [4];

   ascii_decimal_line_parser #(
      .LINE_BUFFER_LEN(LINE_LEN)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_code    (req_char_code),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_status       (rsp_status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("FAIL ascii_decimal_line_parser");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------
   // line predictor
   // ---------------------------------------------------------------

   task automatic clear_line_state();
      line_phase = PH_LEAD;
      line_count = 0;
      line_long  = 1'b0;
      line_acc   = 0;
      line_over  = 1'b0;
      line_digit = 1'b0;
   endtask

   // accumulate one digit; the value freezes once it would pass max_value
   task automatic take_digit(input logic [CHAR_W-1:0] c);
      longint nxt;
      line_digit = 1'b1;
      if (!line_over) begin
         nxt = line_acc * 10 + longint'(c - DIGIT_LO);
         if (nxt > longint'(line_max)) line_over = 1'b1;
         else line_acc = nxt;
      end
   endtask

   task automatic advance_line(input logic [CHAR_W-1:0] c, input logic eoi,
                               output bit got, output line_result_type res);
      bit blank;
      bit digit;
      got = 1'b0;
      res.value  = '0;
      res.status = STATUS_OK;
      blank = (c <= 8'd32) || (c >= 8'd128);
      digit = (c >= 8'd48) && (c <= 8'd57);
      if (eoi) begin
         // end of input wins over everything collected so far
         got = 1'b1;
         res.status = STATUS_READ;
         clear_line_state();
      end else if (c != EOL_CODE) begin
         if (line_count < LINE_LEN) begin
            case (line_phase)
               PH_LEAD: begin
                  if (digit) begin
                     line_phase = PH_DIGITS;
                     take_digit(c);
                  end else if (!blank) line_phase = PH_BAD;
               end
               PH_DIGITS: begin
                  if (digit) take_digit(c);
                  else if (blank) line_phase = PH_TRAIL;
                  else line_phase = PH_BAD;
               end
               PH_TRAIL: begin
                  if (!blank) line_phase = PH_BAD;
               end
               default: ;
            endcase
            line_count++;
         end else begin
            // bytes past the buffer are not looked at
            line_long = 1'b1;
         end
      end else begin
         got = 1'b1;
         if (line_long || line_phase == PH_BAD || !line_digit || line_over) begin
            res.status = STATUS_PARSE;
         end else begin
            res.value = line_acc[VALUE_W-1:0];
         end
         clear_line_state();
      end
   endtask

   // ---------------------------------------------------------------
   // monitor: checks results, predicts accepted items, tracks the register
   // ---------------------------------------------------------------
   always @(posedge clock) begin : monitor
      line_result_type want;
      line_result_type res;
      bit              got;
      if (reset) begin
         line_max = MAX_VALUE_RESET;
         clear_line_state();
      end else begin
         if (csr_wr_en) line_max = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result value %0d status %0d with none expected",
                                         rsp_value, rsp_status));
            end else begin
               want = pending_results.pop_front();
               if (rsp_value !== want.value)
                  report_mismatch($sformatf("value %0d, expected %0d", rsp_value, want.value));
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               results_checked++;
               status_seen[want.status]++;
            end
         end
         if (req_valid && req_ready) begin
            advance_line(req_char_code, req_end_of_input, got, res);
            // a typed row overrides the predicted result
            if (row_typed) begin
               res.value  = row_value;
               res.status = row_status;
               pending_results.push_back(res);
            end else if (got) begin
               pending_results.push_back(res);
            end
         end
      end
   end

   // receiver: random ready and stall bursts, always ready when idling is off
   always @(posedge clock) begin
      if (!idle_en) begin
         rsp_ready  <= 1'b1;
         burst_left <= 0;
      end else if (burst_left == 0) begin
         rsp_ready  <= ($urandom_range(0, 3) != 0);
         burst_left <= $urandom_range(1, 8);
      end else begin
         burst_left <= burst_left - 1;
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   // present one item and hold it until accepted; a gap may come first
   task automatic send_item(input logic [CHAR_W-1:0] code, input logic eoi,
                            input logic typed, input logic [VALUE_W-1:0] tv,
                            input logic [1:0] ts);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_char_code    <= code;
      req_end_of_input <= eoi;
      row_typed        <= typed;
      row_value        <= tv;
      row_status       <= ts;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // stop sending until every expected result is back and the pipe is empty
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      // lines without a result may still be in flight
      repeat (8) @(posedge clock);
   endtask

   task automatic write_max(input logic [VALUE_W-1:0] v);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_writes++;
   endtask

   // blank: space, control codes other than newline, or high-bit bytes
   function automatic logic [CHAR_W-1:0] pick_blank();
      logic [CHAR_W-1:0] b;
      case ($urandom_range(0, 2))
         0: b = BLANK_MAX;
         1: begin
            b = 8'($urandom_range(0, 31));
            if (b == EOL_CODE) b = 8'd0;
         end
         default: b = 8'($urandom_range(128, 255));
      endcase
      return b;
   endfunction

   // any byte but the newline
   function automatic logic [CHAR_W-1:0] pick_any();
      logic [CHAR_W-1:0] b;
      b = 8'($urandom_range(0, 255));
      if (b == EOL_CODE) b = b ^ 8'h01;
      return b;
   endfunction

   task automatic push_number(input longint v);
      logic [CHAR_W-1:0] digits[$];
      if (v == 0) digits.push_front(DIGIT_LO);
      while (v > 0) begin
         digits.push_front(8'(DIGIT_LO + 8'(v % 10)));
         v = v / 10;
      end
      foreach (digits[i]) line_bytes.push_back(digits[i]);
   endtask

   // mostly well-formed lines with random content, some broken, some noise
   task automatic send_random_line();
      int     kind;
      int     n;
      longint num;
      bit     eoi_end;
      line_bytes.delete();
      kind = $urandom_range(0, 15);
      if (kind <= 12) begin
         n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
         // many leading blanks can push the line past the buffer
         if (kind == 12) n = $urandom_range(4, 8);
         repeat (n) line_bytes.push_back(pick_blank());
         case ($urandom_range(0, 5))
            0: num = $urandom_range(0, 9);
            1: num = $urandom_range(0, 99999);
            2: num = longint'(31'($urandom));
            3: num = longint'(line_max);
            // just above the limit, where the sticky flag must trip
            4: num = longint'(line_max) + $urandom_range(1, 9);
            default: begin
               num = longint'(line_max) - $urandom_range(0, 3);
               if (num < 0) num = 0;
            end
         endcase
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) line_bytes.push_back(DIGIT_LO);
         push_number(num);
         repeat ($urandom_range(0, 2)) line_bytes.push_back(pick_blank());
         // broken line: one byte swapped for anything
         if (kind >= 9 && kind <= 11)
            line_bytes[$urandom_range(0, line_bytes.size() - 1)] = pick_any();
      end else begin
         n = $urandom_range(0, 12);
         repeat (n) begin
            case ($urandom_range(0, 2))
               0: line_bytes.push_back(pick_any());
               1: line_bytes.push_back(pick_blank());
               default: line_bytes.push_back(8'(DIGIT_LO + $urandom_range(0, 9)));
            endcase
         end
      end
      eoi_end = ($urandom_range(0, 11) == 0);
      foreach (line_bytes[i]) send_item(line_bytes[i], 1'b0, 1'b0, '0, STATUS_OK);
      if (eoi_end) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0, STATUS_OK);
      else send_item(EOL_CODE, 1'b0, 1'b0, '0, STATUS_OK);
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin : stimulus
      logic [VALUE_W-1:0] new_max;
      int                 start;
      int                 tail;

      directed_rows = '{
         // lone newline right after reset: no digits
         '{ROW_ITEM, EOL_CODE, 1'b0, 1'b1, 31'd0, STATUS_PARSE},
         // lowest and highest blank codes around one digit
         '{ROW_ITEM, 8'd0,     1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, "5",      1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, 8'd255,   1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, EOL_CODE, 1'b0, 1'b1, 31'd5, STATUS_OK},
         // neither blank nor digit
         '{ROW_ITEM, 8'h7F,    1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, EOL_CODE, 1'b0, 1'b1, 31'd0, STATUS_PARSE},
         // end of input on a good prefix, char ignored even when it is a newline
         '{ROW_ITEM, "7",      1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, EOL_CODE, 1'b1, 1'b1, 31'd0, STATUS_READ},
         // eleven bytes: one past the buffer
         '{ROW_ITEM, "9",      1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, "8",      1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, "7",      1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, "6",      1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, "5",      1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, "4",      1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, "3",      1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, "2",      1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, "1",      1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, "0",      1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, "5",      1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, EOL_CODE, 1'b0, 1'b1, 31'd0, STATUS_PARSE},
         // max_value at its bottom: 1 is over, 0 still fits
         '{ROW_CFG,  8'd0,     1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, "1",      1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, EOL_CODE, 1'b0, 1'b1, 31'd0, STATUS_PARSE},
         '{ROW_ITEM, "0",      1'b0, 1'b0, 31'd0, STATUS_OK},
         '{ROW_ITEM, EOL_CODE, 1'b0, 1'b0, 31'd0, STATUS_OK}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            write_max(directed_rows[i].val);
         end else begin
            send_item(directed_rows[i].code, directed_rows[i].eoi, directed_rows[i].typed,
                      directed_rows[i].val, directed_rows[i].st);
         end
      end

      // random phases, each under its own max_value; the register write
      // doubles as a full pause until every result is back
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: new_max = MAX_VALUE_RESET;
            1: new_max = 31'd0;
            3: new_max = 31'd9;
            4: new_max = 31'd1000;
            5: new_max = 31'($urandom_range(0, 99999));
            6: new_max = 31'h7FFF_FFFE;
            7: new_max = 31'h4000_0000;
            9: new_max = MAX_VALUE_RESET;
            default: new_max = 31'($urandom);
         endcase
         write_max(new_max);
         // one calm phase in the middle, and none at all at the end
         idle_en = (ph != 4) && (ph != PHASES - 1);
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            send_random_line();
            if (ph != 4 && ph != PHASES - 1 && $urandom_range(0, 29) == 0) idle_en = !idle_en;
         end
      end

      // wait out the remaining results, then the pipe latency
      req_valid <= 1'b0;
      tail = 0;
      @(posedge clock);
      while (pending_results.size() != 0 && tail < 5000) begin
         @(posedge clock);
         tail++;
      end
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   pending_results.size()));

      $display("ran %0d character items over %0d max_value settings, %0d results checked",
               items_sent, cfg_writes, results_checked);
      $display("results by status: ok %0d, parse error %0d, read error %0d, mismatches %0d",
               status_seen[STATUS_OK], status_seen[STATUS_PARSE], status_seen[STATUS_READ],
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS ascii_decimal_line_parser");
      end else begin
         $display("FAIL ascii_decimal_line_parser");
      end
      $finish;
   end

endmodule
